// ===== design/rkt_pkg.sv =====
// rkt_pkg: shared constants, codes and types of the ranked key table
`default_nettype none

package rkt_pkg;

    localparam int CAPACITY = 128;
    localparam int CAP_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ID_W     = 7;
    localparam int KEY_W    = 32;
    localparam int RANK_W   = 7;
    localparam int CMD_W    = 2;
    localparam int STAT_W   = 3;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd1;

    localparam logic [STAT_W-1:0] STAT_OK      = 3'd0;
    localparam logic [STAT_W-1:0] STAT_FULL    = 3'd1;
    localparam logic [STAT_W-1:0] STAT_ABSENT  = 3'd2;
    localparam logic [STAT_W-1:0] STAT_PRESENT = 3'd3;
    localparam logic [STAT_W-1:0] STAT_EMPTY   = 3'd4;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INS,
        CELL_DEL
    } cell_op_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECIDE,
        S_RECMP
    } state_t;

    typedef struct packed {
        logic [ID_W-1:0]         id;
        logic signed [KEY_W-1:0] key;
    } cell_data_t;

    typedef struct packed {
        cell_op_t                op;
        logic                    cmp_en;
        logic [ID_W-1:0]         id;
        logic signed [KEY_W-1:0] key;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== design/rkt_cell.sv =====
// rkt_cell: one slot of the sorted chain, with its id/key compare and shift mux
`default_nettype none

module rkt_cell
    import rkt_pkg::*;
(
    input  wire logic       clk,
    input  wire cell_ctrl_t ctrl,
    input  wire logic       occ,
    input  wire logic       prev_stay,
    input  wire logic       del_here,
    input  wire cell_data_t prev_data,
    input  wire cell_data_t next_data,
    output cell_data_t      data,
    output logic            stay,
    output logic            match
);

    cell_data_t data_reg;
    cell_data_t data_next;
    logic       stay_reg;
    logic       stay_next;
    logic       match_reg;
    logic       match_next;

    always_comb
    begin
        data_next = data_reg;
        case (ctrl.op)
            CELL_INS:
            begin
                if (!stay_reg)
                begin
                    if (prev_stay)
                    begin
                        data_next.id  = ctrl.id;
                        data_next.key = ctrl.key;
                    end
                    else
                    begin
                        data_next = prev_data;
                    end
                end
            end
            CELL_DEL:
            begin
                if (del_here)
                begin
                    data_next = next_data;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    // stay: this entry keeps its place ahead of the new key
    always_comb
    begin
        stay_next  = stay_reg;
        match_next = match_reg;
        if (ctrl.cmp_en)
        begin
            stay_next  = occ && ($signed(data_reg.key) >= $signed(ctrl.key));
            match_next = occ && (data_reg.id == ctrl.id);
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg  <= data_next;
        stay_reg  <= stay_next;
        match_reg <= match_next;
    end

    assign data  = data_reg;
    assign stay  = stay_reg;
    assign match = match_reg;

endmodule

`default_nettype wire

// ===== design/ranked_key_table_top.sv =====
// ranked_key_table_top: sorted table of id/key items held in a chain of cells
//
//  channel | direction | handshake            | fields
//  --------+-----------+----------------------+------------------------------------------
//  in      | in        | in_valid / in_ready  | command, item_id, key, rank_in
//  out     | out       | out_valid / out_ready| status, rank_out, item_id_out, key_out
//
// insert, read and error results: all cells compare at accept, then one decide step once the output is free
// update of a stored id: compare, remove shift, compare again, insert shift
// one item in flight at a time; the next is taken once the final decide step is done
// a result waits in the output register while the next item is accepted
// rst_n clears the entry count, the sequencer and the output valid
`default_nettype none

module ranked_key_table_top
    import rkt_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [CMD_W-1:0]        command,
    input  wire logic [ID_W-1:0]         item_id,
    input  wire logic signed [KEY_W-1:0] key,
    input  wire logic [RANK_W-1:0]       rank_in,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [STAT_W-1:0]            status,
    output logic [RANK_W-1:0]            rank_out,
    output logic [ID_W-1:0]              item_id_out,
    output logic signed [KEY_W-1:0]      key_out
);

    state_t                  state_reg;
    state_t                  state_next;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic                    reins_reg;
    logic                    reins_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;

    logic [CMD_W-1:0]        cmd_reg;
    logic [ID_W-1:0]         id_reg;
    logic signed [KEY_W-1:0] key_reg;
    logic [RANK_W-1:0]       rank_reg;
    logic [CAPACITY-1:0]     rd_sel_reg;
    logic [CAPACITY-1:0]     rd_sel_next;

    logic [STAT_W-1:0]       status_reg;
    logic [STAT_W-1:0]       status_next;
    logic [RANK_W-1:0]       rank_out_reg;
    logic [RANK_W-1:0]       rank_out_next;
    logic [ID_W-1:0]         id_out_reg;
    logic [ID_W-1:0]         id_out_next;
    logic signed [KEY_W-1:0] key_out_reg;
    logic signed [KEY_W-1:0] key_out_next;

    cell_ctrl_t              ctrl;
    cell_data_t              cell_data [CAPACITY];
    cell_data_t              cell_prev [CAPACITY];
    cell_data_t              cell_nxt  [CAPACITY];
    logic [CAPACITY-1:0]     stay_vec;
    logic [CAPACITY-1:0]     match_vec;
    logic [CAPACITY-1:0]     prev_stay_vec;
    logic [CAPACITY-1:0]     occ_vec;
    logic [CAPACITY-1:0]     del_vec;

    logic                    accept;
    logic                    out_free;
    logic                    found;
    logic [CAP_W-1:0]        found_pos;
    logic [CAP_W-1:0]        ins_pos;
    logic [ID_W-1:0]         rd_id;
    logic signed [KEY_W-1:0] rd_key;

    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // cell chain
    generate
        for (genvar i = 0; i < CAPACITY; i++)
        begin : g_cell
            assign occ_vec[i] = CNT_W'(i) < count_reg;
            assign del_vec[i] = CAP_W'(i) >= found_pos;
            if (i == 0)
            begin : g_first
                assign prev_stay_vec[i] = 1'b1;
                assign cell_prev[i]     = cell_data[i];
            end
            else
            begin : g_mid
                assign prev_stay_vec[i] = stay_vec[i-1];
                assign cell_prev[i]     = cell_data[i-1];
            end
            if (i == CAPACITY - 1)
            begin : g_last
                assign cell_nxt[i] = cell_data[i];
            end
            else
            begin : g_body
                assign cell_nxt[i] = cell_data[i+1];
            end

            rkt_cell u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .occ       (occ_vec[i]),
                .prev_stay (prev_stay_vec[i]),
                .del_here  (del_vec[i]),
                .prev_data (cell_prev[i]),
                .next_data (cell_nxt[i]),
                .data      (cell_data[i]),
                .stay      (stay_vec[i]),
                .match     (match_vec[i])
            );
        end
    endgenerate

    // one-hot combine of the registered cell flags
    always_comb
    begin
        found     = |match_vec;
        found_pos = '0;
        ins_pos   = '0;
        rd_id     = '0;
        rd_key    = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (match_vec[i])
            begin
                found_pos = found_pos | CAP_W'(i);
            end
            if (prev_stay_vec[i] && !stay_vec[i])
            begin
                ins_pos = ins_pos | CAP_W'(i);
            end
            if (rd_sel_reg[i])
            begin
                rd_id  = rd_id | cell_data[i].id;
                rd_key = rd_key | cell_data[i].key;
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            rd_sel_next[i] = (CAP_W'(rank_in) == CAP_W'(i));
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        reins_next     = reins_reg;
        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;
        rank_out_next  = rank_out_reg;
        id_out_next    = id_out_reg;
        key_out_next   = key_out_reg;
        in_ready       = 1'b0;
        ctrl.op        = CELL_HOLD;
        ctrl.cmp_en    = 1'b0;
        ctrl.id        = id_reg;
        ctrl.key       = key_reg;

        case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                ctrl.cmp_en = 1'b1;
                ctrl.id     = item_id;
                ctrl.key    = key;
                if (in_valid)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_RECMP:
            begin
                ctrl.cmp_en = 1'b1;
                state_next  = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (out_free)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                    status_next    = STAT_OK;
                    rank_out_next  = '0;
                    id_out_next    = '0;
                    key_out_next   = '0;
                    if (reins_reg)
                    begin
                        ctrl.op       = CELL_INS;
                        count_next    = count_reg + 1'b1;
                        reins_next    = 1'b0;
                        rank_out_next = RANK_W'(ins_pos);
                        id_out_next   = id_reg;
                        key_out_next  = key_reg;
                    end
                    else if (cmd_reg[1])
                    begin
                        if (CNT_W'(rank_reg) < count_reg)
                        begin
                            rank_out_next = rank_reg;
                            id_out_next   = rd_id;
                            key_out_next  = rd_key;
                        end
                        else
                        begin
                            status_next = STAT_EMPTY;
                        end
                    end
                    else if (cmd_reg == CMD_INSERT)
                    begin
                        if (found)
                        begin
                            status_next = STAT_PRESENT;
                        end
                        else if (count_reg == CNT_W'(CAPACITY))
                        begin
                            status_next = STAT_FULL;
                        end
                        else
                        begin
                            ctrl.op       = CELL_INS;
                            count_next    = count_reg + 1'b1;
                            rank_out_next = RANK_W'(ins_pos);
                            id_out_next   = id_reg;
                            key_out_next  = key_reg;
                        end
                    end
                    else
                    begin
                        if (!found)
                        begin
                            status_next = STAT_ABSENT;
                        end
                        else
                        begin
                            // take the old entry out, then compare again
                            ctrl.op        = CELL_DEL;
                            count_next     = count_reg - 1'b1;
                            reins_next     = 1'b1;
                            state_next     = S_RECMP;
                            out_valid_next = out_valid_reg && !out_ready;
                            status_next    = status_reg;
                            rank_out_next  = rank_out_reg;
                            id_out_next    = id_out_reg;
                            key_out_next   = key_out_reg;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            reins_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            reins_reg     <= reins_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= command;
            id_reg     <= item_id;
            key_reg    <= key;
            rank_reg   <= rank_in;
            rd_sel_reg <= rd_sel_next;
        end
        status_reg   <= status_next;
        rank_out_reg <= rank_out_next;
        id_out_reg   <= id_out_next;
        key_out_reg  <= key_out_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign rank_out    = rank_out_reg;
    assign item_id_out = id_out_reg;
    assign key_out     = key_out_reg;

endmodule

`default_nettype wire

// ===== design/rkt_checker.sv =====
// rkt_checker: port-level checks of the ranked key table, bound to the top level
`default_nettype none

module rkt_checker
    import rkt_pkg::*;
(
    input wire logic                    clk,
    input wire logic                    rst_n,
    input wire logic                    in_valid,
    input wire logic                    in_ready,
    input wire logic [CMD_W-1:0]        command,
    input wire logic [ID_W-1:0]         item_id,
    input wire logic signed [KEY_W-1:0] key,
    input wire logic [RANK_W-1:0]       rank_in,
    input wire logic                    out_valid,
    input wire logic                    out_ready,
    input wire logic [STAT_W-1:0]       status,
    input wire logic [RANK_W-1:0]       rank_out,
    input wire logic [ID_W-1:0]         item_id_out,
    input wire logic signed [KEY_W-1:0] key_out
);

    // a waiting result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(rank_out)
            && $stable(item_id_out) && $stable(key_out))
        else $error("result changed while stalled");

    // one item at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("item accepted while previous one in progress");

    // error results carry zero fields
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STAT_OK |-> rank_out == '0 && item_id_out == '0
            && key_out == '0)
        else $error("error result with nonzero fields");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status == STAT_OK || status == STAT_FULL || status == STAT_ABSENT
            || status == STAT_PRESENT || status == STAT_EMPTY)
        else $error("status code out of range");

    // a new result only appears after an accepted item
    a_no_result_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result without item in progress");

endmodule

bind ranked_key_table_top rkt_checker u_rkt_checker (.*);

`default_nettype wire
